[rtl/core/rc4sc_pkg.sv]
package rc4sc_pkg;

    // Key store depth and derived widths
    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KEY_CW    = $clog2(KEY_DEPTH + 1);

    localparam int DROP_W    = 12;
    localparam int PERM_N    = 256;

    // req_type codes
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
        logic       key_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] keystream_byte;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic idx_clr;   // i = j = 0
        logic init_wr;   // S[i] = i, i advances and holds at 255
        logic rd;        // i = i + 1, read S[i] and key[k]
        logic add;       // j += S[i] (+ key), read S[j]
        logic use_key;   // key scheduling step
        logic sw1;       // S[i] = S[j], read S[t]
        logic sw2;       // S[j] = old S[i], keystream ready
        logic byte_ld;   // capture data byte
        logic key_wr;    // store key byte
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic i_last;    // i == 255
    } t_dp_stat;

endpackage

[rtl/core/rc4sc_datapath.sv]
module rc4sc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rc4sc_pkg::t_dp_cmd   i_cmd,
    input  rc4sc_pkg::t_in       i_in,
    output rc4sc_pkg::t_dp_stat  o_stat,
    output rc4sc_pkg::t_out      o_res
);

    logic [7:0] perm_mem [rc4sc_pkg::PERM_N];
    logic [7:0] key_mem  [rc4sc_pkg::KEY_DEPTH];

    logic [7:0] r_i, n_i;
    logic [7:0] r_j, n_j;
    logic [7:0] r_a;
    logic [7:0] r_byte;
    logic [7:0] r_q_a, r_q_b, r_key_q;
    logic [rc4sc_pkg::KEY_AW-1:0] r_k, n_k;
    logic [rc4sc_pkg::KEY_CW-1:0] r_key_count, n_key_count;
    logic [rc4sc_pkg::KEY_CW-1:0] r_key_len, n_key_len;

    logic [7:0] i_inc;
    logic [7:0] j_sum;
    logic [7:0] t_sw1;
    logic [7:0] t_sw2;
    logic [7:0] ra_addr;
    logic       ra_en;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       key_room;
    logic [rc4sc_pkg::KEY_CW-1:0] key_count_inc;
    logic [rc4sc_pkg::KEY_CW-1:0] k_inc;
    logic [7:0] ks;

    assign i_inc = r_i + 8'd1;
    assign j_sum = r_j + r_q_a + (i_cmd.use_key ? r_key_q : 8'd0);
    assign t_sw1 = r_a + r_q_b;
    assign t_sw2 = r_a + r_q_b;

    assign ra_en   = i_cmd.rd | i_cmd.sw1;
    assign ra_addr = i_cmd.rd ? i_inc : t_sw1;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = r_i;
        if (i_cmd.init_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.sw1) begin
            wr_en   = 1'b1;
            wr_data = r_q_b;
        end else if (i_cmd.sw2) begin
            wr_en   = 1'b1;
            wr_addr = r_j;
            wr_data = r_a;
        end
    end

    // permutation table: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            perm_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ra_en) begin
            r_q_a <= perm_mem[ra_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_q_b <= perm_mem[j_sum];
        end
    end

    // key store
    assign key_room      = (r_key_count < rc4sc_pkg::KEY_CW'(rc4sc_pkg::KEY_DEPTH));
    assign key_count_inc = r_key_count + rc4sc_pkg::KEY_CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_wr && key_room) begin
            key_mem[r_key_count[rc4sc_pkg::KEY_AW-1:0]] <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_key_q <= key_mem[r_k];
        end
    end

    // key index wraps at key length
    assign k_inc = rc4sc_pkg::KEY_CW'(r_k) + rc4sc_pkg::KEY_CW'(1);

    always_comb begin
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_key_count = r_key_count;
        n_key_len   = r_key_len;
        if (i_cmd.init_wr && (r_i != 8'hFF)) begin
            n_i = i_inc;
        end
        if (i_cmd.rd) begin
            n_i = i_inc;
        end
        if (i_cmd.add) begin
            n_j = j_sum;
        end
        if (i_cmd.sw2 && i_cmd.use_key) begin
            n_k = (k_inc == r_key_len) ? '0 : k_inc[rc4sc_pkg::KEY_AW-1:0];
        end
        if (i_cmd.key_wr) begin
            if (key_room) begin
                n_key_count = key_count_inc;
            end
            if (i_in.key_last) begin
                n_key_len   = key_room ? key_count_inc : r_key_count;
                n_key_count = '0;
                n_k         = '0;
            end
        end
        if (i_cmd.idx_clr) begin
            n_i = '0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_key_count <= '0;
            r_key_len   <= rc4sc_pkg::KEY_CW'(1);
        end else begin
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_key_count <= n_key_count;
            r_key_len   <= n_key_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            r_a <= r_q_a;
        end
        if (i_cmd.byte_ld) begin
            r_byte <= i_in.in_byte;
        end
    end

    // S[t] read before the second swap write; forward the swapped values
    always_comb begin
        if (t_sw2 == r_j) begin
            ks = r_a;
        end else if (t_sw2 == r_i) begin
            ks = r_q_b;
        end else begin
            ks = r_q_a;
        end
    end

    assign o_res.keystream_byte = ks;
    assign o_res.out_byte       = r_byte ^ ks;
    assign o_stat.i_last        = (r_i == 8'hFF);

endmodule

[rtl/core/rc4sc_ctrl.sv]
module rc4sc_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  rc4sc_pkg::t_in                    i_in,
    output logic                              o_in_stall,
    input  logic                              i_out_free,
    output logic                              o_emit,
    input  logic                              i_cfg_we,
    input  logic [rc4sc_pkg::DROP_W-1:0]      i_cfg_data,
    input  rc4sc_pkg::t_dp_stat               i_stat,
    output rc4sc_pkg::t_dp_cmd                o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_INIT = 6'b000010,
        ST_RD   = 6'b000100,
        ST_ADD  = 6'b001000,
        ST_SW1  = 6'b010000,
        ST_SW2  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        MODE_DATA = 2'd0,
        MODE_KSA  = 2'd1,
        MODE_DROP = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_init_ksa, n_init_ksa;
    logic [rc4sc_pkg::DROP_W-1:0] r_drop_count;
    logic [rc4sc_pkg::DROP_W-1:0] r_drop_left, n_drop_left;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_init_ksa  = r_init_ksa;
        n_drop_left = r_drop_left;
        o_cmd       = '0;
        o_emit      = 1'b0;
        o_cmd.use_key = (r_mode == MODE_KSA);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.req_type == rc4sc_pkg::REQ_DATA) begin
                        o_cmd.rd      = 1'b1;
                        o_cmd.byte_ld = 1'b1;
                        n_mode        = MODE_DATA;
                        n_state       = ST_ADD;
                    end else begin
                        o_cmd.key_wr = 1'b1;
                        if (i_in.key_last) begin
                            o_cmd.idx_clr = 1'b1;
                            n_init_ksa    = 1'b1;
                            n_state       = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.i_last) begin
                    if (r_init_ksa) begin
                        n_mode  = MODE_KSA;
                        n_state = ST_RD;
                    end else begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_SW1;
            end
            ST_SW1: begin
                o_cmd.sw1 = 1'b1;
                n_state   = ST_SW2;
            end
            ST_SW2: begin
                case (r_mode)
                    MODE_DATA: begin
                        if (i_out_free) begin
                            o_cmd.sw2 = 1'b1;
                            o_emit    = 1'b1;
                            n_state   = ST_IDLE;
                        end
                    end
                    MODE_KSA: begin
                        o_cmd.sw2 = 1'b1;
                        if (i_stat.i_last) begin
                            o_cmd.idx_clr = 1'b1;
                            n_init_ksa    = 1'b0;
                            if (r_drop_count == '0) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_drop_left = r_drop_count;
                                n_mode      = MODE_DROP;
                                n_state     = ST_RD;
                            end
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                    default: begin
                        o_cmd.sw2   = 1'b1;
                        n_drop_left = r_drop_left - rc4sc_pkg::DROP_W'(1);
                        if (r_drop_left == rc4sc_pkg::DROP_W'(1)) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_RD;
                        end
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_mode       <= MODE_DATA;
            r_init_ksa   <= 1'b0;
            r_drop_left  <= '0;
            r_drop_count <= '0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_init_ksa  <= n_init_ksa;
            r_drop_left <= n_drop_left;
            if (i_cfg_we) begin
                r_drop_count <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/core/rc4_stream_cipher.sv]
// Channel  | Signals                            | Beat
// ---------+------------------------------------+--------------------------------------
// input    | i_in_valid, o_in_stall, i_in       | key byte (req_type 0) or data byte
// output   | o_out_valid, i_out_stall, o_out    | out_byte and keystream_byte
// config   | i_cfg_we, i_cfg_data               | drop_count, 12 bits, no read-back
//
// Key byte: stored on acceptance, input stays open. Data byte: accept, read S[j],
// two swap writes (split by the single write port of the permutation RAM), input stalled.
// Last key byte: identity fill, key schedule rounds, then drop_count dropped rounds.
// Reset: synchronous, active low; an identity fill follows, o_in_stall high.
// A waiting result sits in the output register; a data byte holds in its
// last step only while that register is full and stalled.
module rc4_stream_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rc4sc_pkg::t_in                i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rc4sc_pkg::t_out               o_out,
    input  logic                          i_cfg_we,
    input  logic [rc4sc_pkg::DROP_W-1:0]  i_cfg_data
);

    rc4sc_pkg::t_dp_cmd  cmd;
    rc4sc_pkg::t_dp_stat stat;
    rc4sc_pkg::t_out     res;
    logic                emit;
    logic                out_free;

    logic                r_out_valid;
    rc4sc_pkg::t_out     r_out;

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    rc4sc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_out_free (out_free),
        .o_emit     (emit),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rc4sc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
